### rtl/core/sia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sia_pkg;

  // field widths of the stream words
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_W     = 9;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_MOD  = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_HALTED  = 3'd4
  } status_t;

endpackage

`default_nettype wire

### rtl/core/sia_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sia_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sia_pkg::DATA_W-1:0] dividend,
  input  wire logic [sia_pkg::DATA_W-1:0] divisor,
  output logic                           done,
  output logic [sia_pkg::DATA_W-1:0]     quotient,
  output logic [sia_pkg::DATA_W-1:0]     remainder
);
  import sia_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic              busy_r;
  logic              fin_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dsr_r;
  logic              neg_q_r;
  logic              neg_r_r;
  logic [DATA_W-1:0] quotient_r;
  logic [DATA_W-1:0] remainder_r;

  logic [DATA_W:0]   rem_w;
  logic [DATA_W:0]   diff;

  // one restoring step: shift in the next dividend bit and try to subtract
  always_comb begin
    rem_w = {rem_r, quo_r[DATA_W-1]};
    diff  = rem_w - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        // work on magnitudes, signs applied at the end
        quo_r   <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
        dsr_r   <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
        rem_r   <= '0;
        neg_q_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        neg_r_r <= dividend[DATA_W-1];
        step_r  <= STEP_W'(DATA_W - 1);
        busy_r  <= 1'b1;
        done_r  <= 1'b0;
      end else if (busy_r) begin
        if (!diff[DATA_W]) begin
          rem_r <= diff[DATA_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_w[DATA_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b0};
        end
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
        done_r <= 1'b0;
      end else if (fin_r) begin
        // truncating division: remainder follows the dividend sign
        quotient_r  <= neg_q_r ? (DATA_W'(0) - quo_r) : quo_r;
        remainder_r <= neg_r_r ? (DATA_W'(0) - rem_r) : rem_r;
        fin_r       <= 1'b0;
        done_r      <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quotient_r;
  assign remainder = remainder_r;

endmodule

`default_nettype wire

### rtl/core/stack_integer_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer operand stack executor.
// The in_ stream carries one command word: a push of a signed 32-bit
// constant, or add, sub, mul, div or mod on the two top stack entries.
// The out_ stream returns exactly one word per command: status, the new
// top of stack (0 when empty) and the new depth.
// Commands are taken one at a time. A push, an unknown code, an empty
// stack or a halted report goes straight to the output register; a zero
// divisor does too, or first refills the cached top by one extra stack
// read when entries remain. Add, sub and mul operate, write back and then
// load the output register; div and mod run the bit-serial divider (start,
// quotient bits, sign fixup, handoff), write back and load the output
// register, which waits while it still holds an untaken word. in_tready
// returns together with the word being loaded, and only then.
// The top entry is cached in a register; the stack memory has one write
// and one registered read port and only one command is in flight, so
// accesses never overlap.
// Reset empties the stack and clears the halt flag; no clearing pass is
// run. After an error the block answers with the halted status until reset.
// While out_tready is low a finished word waits in the output register; one
// further command may be accepted meanwhile.
module stack_integer_alu #(
  parameter int unsigned STACK_ENTRIES = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // command [2:0], constant_value [34:3], zero fill [39:35]
  input  wire logic [sia_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // status [2:0], top_value [34:3], depth [43:35], zero fill [47:44]
  output logic [sia_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import sia_pkg::*;

  localparam int unsigned CNT_W  = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_WB,
    S_REFILL,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [CNT_W-1:0]   count_r;
  logic [DATA_W-1:0]  top_r;
  logic [DATA_W-1:0]  res_r;
  logic               halted_r;
  status_t            status_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // stack memory
  logic [DATA_W-1:0]  stack_mem [STACK_ENTRIES];
  logic [DATA_W-1:0]  rd_data_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  logic               in_acc;
  logic [CMD_W-1:0]   in_cmd;
  logic [DATA_W-1:0]  in_cval;
  logic               in_arith;
  logic               cmd_divmod;
  logic               stack_full;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic [CNT_W-1:0]   cnt_m3;
  logic [DATA_W-1:0]  add_res;
  logic [DATA_W-1:0]  sub_res;
  logic [DATA_W-1:0]  mul_res;
  logic [DATA_W-1:0]  top_out;
  logic [DEPTH_W+CNT_W-1:0] depth_ext;
  logic               out_load;

  logic               div_start;
  logic               div_done;
  logic [DATA_W-1:0]  div_quo;
  logic [DATA_W-1:0]  div_rem;

  // input decode
  always_comb begin
    in_acc     = in_tvalid && in_tready;
    in_cmd     = in_tdata[CMD_W-1:0];
    in_cval    = in_tdata[CMD_W+DATA_W-1:CMD_W];
    in_arith   = (in_cmd >= CMD_ADD) && (in_cmd <= CMD_MOD);
    cmd_divmod = (cmd_r == CMD_DIV) || (cmd_r == CMD_MOD);
    stack_full = (count_r == CNT_W'(STACK_ENTRIES));
    cnt_m1     = count_r - CNT_W'(1);
    cnt_m2     = count_r - CNT_W'(2);
    cnt_m3     = count_r - CNT_W'(3);
    add_res    = rd_data_r + top_r;
    sub_res    = rd_data_r - top_r;
    mul_res    = rd_data_r * top_r;
  end

  // memory port control: push or write back, left operand or refill read
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[ADDR_W-1:0];
    mem_wdata = in_cval;
    mem_re    = 1'b0;
    mem_raddr = cnt_m2[ADDR_W-1:0];
    if (state_r == S_WB) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_m2[ADDR_W-1:0];
      mem_wdata = res_r;
    end else if (in_acc && !halted_r && (in_cmd == CMD_PUSH) && !stack_full) begin
      mem_we = 1'b1;
    end
    if (in_acc && !halted_r && in_arith && (count_r > CNT_W'(1))) begin
      mem_re = 1'b1;
    end else if ((state_r == S_READ) && cmd_divmod && (top_r == '0)
                 && (count_r > CNT_W'(2))) begin
      mem_re    = 1'b1;
      mem_raddr = cnt_m3[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_raddr];
    end
  end

  // divider for div and mod, left operand from memory, right from top
  assign div_start = (state_r == S_READ) && cmd_divmod && (top_r != '0);

  sia_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rd_data_r),
    .divisor   (top_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // result fields as seen after the step
  always_comb begin
    top_out   = (count_r == '0) ? '0 : top_r;
    depth_ext = {{DEPTH_W{1'b0}}, count_r};
    out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end

  // command sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_cmd;
            priority if (halted_r) begin
              status_r <= ST_HALTED;
              state_r  <= S_DONE;
            end else if (in_cmd == CMD_PUSH) begin
              state_r <= S_DONE;
              if (stack_full) begin
                status_r <= ST_FULL;
                halted_r <= 1'b1;
              end else begin
                status_r <= ST_OK;
                top_r    <= in_cval;
                count_r  <= count_r + CNT_W'(1);
              end
            end else if (in_arith) begin
              if (count_r == '0) begin
                status_r <= ST_EMPTY;
                halted_r <= 1'b1;
                state_r  <= S_DONE;
              end else if (count_r == CNT_W'(1)) begin
                // right operand stays popped
                status_r <= ST_EMPTY;
                halted_r <= 1'b1;
                count_r  <= '0;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_READ;
              end
            end else begin
              // unknown command: no operation
              status_r <= ST_OK;
              state_r  <= S_DONE;
            end
          end
        end
        S_READ: begin
          priority if (cmd_divmod && (top_r == '0)) begin
            // both operands stay popped
            status_r <= ST_DIVZERO;
            halted_r <= 1'b1;
            count_r  <= cnt_m2;
            state_r  <= (cnt_m2 != '0) ? S_REFILL : S_DONE;
          end else if (cmd_divmod) begin
            state_r <= S_DIV;
          end else begin
            priority if (cmd_r == CMD_ADD) begin
              res_r <= add_res;
            end else if (cmd_r == CMD_SUB) begin
              res_r <= sub_res;
            end else begin
              res_r <= mul_res;
            end
            state_r <= S_WB;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= (cmd_r == CMD_DIV) ? div_quo : div_rem;
            state_r <= S_WB;
          end
        end
        S_WB: begin
          top_r    <= res_r;
          count_r  <= cnt_m1;
          status_r <= ST_OK;
          state_r  <= S_DONE;
        end
        S_REFILL: begin
          top_r   <= rd_data_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_tdata_r <= {{(OUT_TDATA_W - STATUS_W - DATA_W - DEPTH_W){1'b0}},
                            depth_ext[DEPTH_W-1:0], top_out, status_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // stack depth never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_ENTRIES))
    else $error("stack count beyond capacity");

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag dropped without reset");

  // an error word is only ever shown with the block halted
  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((out_tdata_r[STATUS_W-1:0] == ST_FULL)
                    || (out_tdata_r[STATUS_W-1:0] == ST_EMPTY)
                    || (out_tdata_r[STATUS_W-1:0] == ST_DIVZERO)) |-> halted_r)
    else $error("error reported without halt");

  // divider finishes only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result outside divide wait");

endmodule

`default_nettype wire

### bench/stack_integer_alu_checker.sv
`timescale 1ns / 1ps

// watches both streams, tracks the operand stack and checks every result word
module stack_integer_alu_checker #(
  parameter int unsigned STACK_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // command [2:0], constant_value [34:3], zero fill [39:35]
  input  logic [sia_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // status [2:0], top_value [34:3], depth [43:35], zero fill [47:44]
  input  logic [sia_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending_words
);
  import sia_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   top_value;
    logic [DEPTH_W-1:0]  depth;
  } stack_result_t;

  // shadow copy of the operand stack
  logic [DATA_W-1:0] stack_mem [STACK_ENTRIES];
  int unsigned       stack_depth;
  logic              halted;

  stack_result_t     expected_words [$];
  stack_result_t     got_word;
  stack_result_t     want_word;
  int                errors;

  // signed divide truncating toward zero, remainder follows the dividend
  function automatic logic [DATA_W-1:0] trunc_divide(input logic [DATA_W-1:0] num,
                                                      input logic [DATA_W-1:0] den,
                                                      input logic want_rem);
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
    mag_n = num[DATA_W-1] ? ('0 - num) : num;
    mag_d = den[DATA_W-1] ? ('0 - den) : den;
    quo   = mag_n / mag_d;
    rem   = mag_n % mag_d;
    if (want_rem) begin
      return num[DATA_W-1] ? ('0 - rem) : rem;
    end
    return (num[DATA_W-1] != den[DATA_W-1]) ? ('0 - quo) : quo;
  endfunction

  // one command applied to the shadow stack, giving the word it must answer with
  task automatic execute_command(input logic [CMD_W-1:0] cmd,
                                 input logic [DATA_W-1:0] value,
                                 output stack_result_t res);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] acc;
    status_t           st;
    st  = ST_OK;
    acc = '0;
    if (halted) begin
      st = ST_HALTED;
    end else if (cmd == CMD_PUSH) begin
      if (stack_depth >= STACK_ENTRIES) begin
        st = ST_FULL;
      end else begin
        stack_mem[stack_depth] = value;
        stack_depth++;
      end
    end else if (cmd <= CMD_MOD) begin
      if (stack_depth == 0) begin
        st = ST_EMPTY;
      end else begin
        stack_depth--;
        rhs = stack_mem[stack_depth];
        if (stack_depth == 0) begin
          // right operand stays popped
          st = ST_EMPTY;
        end else begin
          stack_depth--;
          lhs = stack_mem[stack_depth];
          if ((cmd == CMD_DIV || cmd == CMD_MOD) && rhs == '0) begin
            // both operands stay popped
            st = ST_DIVZERO;
          end else begin
            case (cmd)
              CMD_ADD: acc = lhs + rhs;
              CMD_SUB: acc = lhs - rhs;
              CMD_MUL: acc = lhs * rhs;
              CMD_DIV: acc = trunc_divide(lhs, rhs, 1'b0);
              default: acc = trunc_divide(lhs, rhs, 1'b1);
            endcase
            stack_mem[stack_depth] = acc;
            stack_depth++;
          end
        end
      end
    end
    // unknown codes fall through with no effect

    if (st != ST_OK && st != ST_HALTED) begin
      halted = 1'b1;
    end
    res.status    = st;
    res.top_value = (stack_depth != 0) ? stack_mem[stack_depth-1] : '0;
    res.depth     = stack_depth[DEPTH_W-1:0];
  endtask

  // result words are checked before the new command is queued
  always @(posedge clk) begin
    if (!rst_n) begin
      stack_depth = 0;
      halted      = 1'b0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_word.status    = status_t'(out_tdata[STATUS_W-1:0]);
        got_word.top_value = out_tdata[STATUS_W +: DATA_W];
        got_word.depth     = out_tdata[STATUS_W+DATA_W +: DEPTH_W];
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual status %0d top %0d depth %0d",
                   $time, got_word.status, $signed(got_word.top_value), got_word.depth);
          errors++;
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.status != want_word.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want_word.status, got_word.status);
            errors++;
          end
          if (got_word.top_value != want_word.top_value) begin
            $display("%0t: top_value mismatch, expected %0d actual %0d", $time,
                     $signed(want_word.top_value), $signed(got_word.top_value));
            errors++;
          end
          if (got_word.depth != want_word.depth) begin
            $display("%0t: depth mismatch, expected %0d actual %0d",
                     $time, want_word.depth, got_word.depth);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        execute_command(in_tdata[CMD_W-1:0], in_tdata[CMD_W +: DATA_W], want_word);
        expected_words.push_back(want_word);
      end
    end
    fail_count    <= errors;
    pending_words <= expected_words.size();
  end

endmodule

### bench/stack_integer_alu_test.sv
`timescale 1ns / 1ps

module stack_integer_alu_test;
  import sia_pkg::*;

  localparam int unsigned ENTRIES    = 256;
  localparam int          IDLE_LIMIT = 1000;
  localparam int          IDLE_PCT   = 11;

  localparam logic [CMD_W-1:0]  CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_SPARE_7 = 3'd7;
  localparam logic [DATA_W-1:0] INT_MIN     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX     = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MINUS_ONE   = 32'hffff_ffff;

  // which error ends the run; only one can happen since reset comes once
  typedef enum int {
    FAULT_EMPTY_RIGHT,
    FAULT_EMPTY_LEFT,
    FAULT_FULL,
    FAULT_DIV_ZERO,
    FAULT_MOD_ZERO
  } fault_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // command [2:0], constant_value [34:3], zero fill [39:35]
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // status [2:0], top_value [34:3], depth [43:35], zero fill [47:44]
  logic [OUT_TDATA_W-1:0] out_tdata;

  int   fail_count;
  int   pending_words;
  int   stack_depth;
  logic quiet;

  stack_integer_alu #(
    .STACK_ENTRIES(ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  stack_integer_alu_checker #(
    .STACK_ENTRIES(ENTRIES)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // stop when no word moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one command word, with random gaps ahead of it
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-CMD_W-DATA_W){1'b0}}, value, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_value(input logic [DATA_W-1:0] value);
    send_word(CMD_PUSH, value);
    stack_depth++;
  endtask

  // arithmetic word; the constant field carries junk since it is ignored
  task automatic apply_op(input cmd_t cmd);
    send_word(cmd, $urandom());
    stack_depth--;
  endtask

  task automatic apply_random_alu();
    case ($urandom_range(0, 2))
      0:       apply_op(CMD_ADD);
      1:       apply_op(CMD_SUB);
      default: apply_op(CMD_MUL);
    endcase
  endtask

  // operand values biased toward the corners
  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return MINUS_ONE;
      3:       return '0;
      4:       return 32'd1;
      5:       return 32'($signed($urandom_range(0, 32)) - 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_nonzero();
    logic [DATA_W-1:0] v;
    do v = rand_value(); while (v == '0);
    return v;
  endfunction

  // one random step kept clear of errors: divides get a fresh nonzero divisor
  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_word(pick[0] ? CMD_SPARE_7 : CMD_SPARE_6, $urandom());
    end else if (stack_depth < 2 || (pick < 50 && stack_depth < 40)) begin
      push_value(rand_value());
    end else if (pick < 80) begin
      apply_random_alu();
    end else begin
      push_value(rand_nonzero());
      apply_op(pick[0] ? CMD_DIV : CMD_MOD);
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    fault_t fault;
    int     roll;
    int     n_steps;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    rst_n       <= 1'b0;
    quiet       = 1'b0;
    stack_depth = 0;

    roll = $urandom_range(0, 9);
    if (roll == 0)      fault = FAULT_EMPTY_RIGHT;
    else if (roll < 4)  fault = FAULT_FULL;
    else if (roll < 6)  fault = FAULT_EMPTY_LEFT;
    else if (roll < 8)  fault = FAULT_DIV_ZERO;
    else                fault = FAULT_MOD_ZERO;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack for the right operand is only reachable right after reset
    if (fault == FAULT_EMPTY_RIGHT) begin
      apply_random_alu();
    end

    // most negative over minus one, both quotient and remainder
    push_value(INT_MIN);
    push_value(MINUS_ONE);
    apply_op(CMD_DIV);
    push_value(INT_MIN);
    push_value(MINUS_ONE);
    apply_op(CMD_MOD);
    apply_op(CMD_ADD);
    push_value(INT_MAX);
    apply_op(CMD_ADD);
    // wrap on add, sub and mul
    push_value(INT_MAX);
    push_value(32'd1);
    apply_op(CMD_ADD);
    push_value(INT_MIN);
    push_value(32'd1);
    apply_op(CMD_SUB);
    push_value(32'h0001_0000);
    push_value(32'h0001_0000);
    apply_op(CMD_MUL);
    // negative dividend truncates toward zero
    push_value(32'hffff_fff9);
    push_value(32'd2);
    apply_op(CMD_DIV);
    push_value(32'hffff_fff9);
    push_value(32'd2);
    apply_op(CMD_MOD);
    // unknown codes leave the stack alone
    send_word(CMD_SPARE_6, MINUS_ONE);
    send_word(CMD_SPARE_7, '0);

    // random mix, part of it with no idling at all; longer when no fill follows
    n_steps = (fault == FAULT_EMPTY_LEFT) ? 330 : 150;
    for (int i = 0; i < n_steps; i++) begin
      quiet = (i >= 50 && i < 130);
      random_step();
    end
    quiet = 1'b0;

    // closing error, then a few words answered as halted
    case (fault)
      FAULT_EMPTY_LEFT: begin
        while (stack_depth > 1) apply_random_alu();
        apply_random_alu();
      end
      default: begin
        // use the whole capacity first
        while (stack_depth < int'(ENTRIES)) push_value(rand_value());
        if (fault == FAULT_FULL) begin
          push_value(rand_value());
        end else if (fault != FAULT_EMPTY_RIGHT) begin
          apply_random_alu();
          push_value('0);
          apply_op(fault == FAULT_DIV_ZERO ? CMD_DIV : CMD_MOD);
        end
      end
    endcase
    for (int i = 0; i < 10; i++) begin
      random_step();
    end
    in_tvalid <= 1'b0;

    // drain, then a margin for any stray word
    while (pending_words != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fail_count == 0 && pending_words == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sia_pkg.sv
rtl/core/sia_div.sv
rtl/core/stack_integer_alu.sv
bench/stack_integer_alu_checker.sv
bench/stack_integer_alu_test.sv
